### hw/rtl/aip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types, character codes and mode codes for the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

    typedef logic [2:0] mode_t;

    localparam mode_t MODE_S32 = 3'd0;
    localparam mode_t MODE_S64 = 3'd1;
    localparam mode_t MODE_U32 = 3'd2;
    localparam mode_t MODE_U64 = 3'd3;
    localparam mode_t MODE_H32 = 3'd4;
    localparam mode_t MODE_H64 = 3'd5;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // Finished string handed from the accumulator to the output stage
    typedef struct packed {
        logic [63:0] acc;
        logic        negative;
        logic        illegal;
        logic        wide;
    } aip_fin_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } aip_digit_t;

    function automatic aip_digit_t aip_digit(input logic [7:0] ch, input logic hex);
        aip_digit_t d;
        logic [7:0] t;
        d = '0;
        t = '0;
        if (ch >= CH_0 && ch <= CH_9)
        begin
            t = ch - CH_0;
            d.ok = 1'b1;
            d.val = t[3:0];
        end
        else if (hex && ch >= CH_UA && ch <= CH_UF)
        begin
            t = ch - CH_UA + 8'd10;
            d.ok = 1'b1;
            d.val = t[3:0];
        end
        else if (hex && ch >= CH_LA && ch <= CH_LF)
        begin
            t = ch - CH_LA + 8'd10;
            d.ok = 1'b1;
            d.val = t[3:0];
        end
        return d;
    endfunction

endpackage

### hw/rtl/aip_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_if
// Valid/ready channels of the parser: character stream in, result out.
// ----------------------------------------------------------------------------
interface aip_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;
    logic [2:0] mode;

    modport source (output valid, char_code, last_char, mode, input ready);
    modport sink   (input valid, char_code, last_char, mode, output ready);
endinterface

interface aip_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        rejected;

    modport source (output valid, value, rejected, input ready);
    modport sink   (input valid, value, rejected, output ready);
endinterface

### hw/rtl/aip_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_accum
// Input register and running accumulator; captures a finished string.
// ----------------------------------------------------------------------------
module aip_accum
    import aip_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    aip_char_if.sink          char_in,
    output logic              fin_valid,
    input  logic              fin_ready,
    output aip_fin_t          fin
);

    logic        in_v_reg;
    logic [7:0]  ch_reg;
    logic        last_reg;
    mode_t       in_mode_reg;

    logic [63:0] acc_reg;
    logic        neg_reg;
    logic        ill_reg;
    logic        first_reg;
    mode_t       mode_reg;

    logic        fin_v_reg;
    aip_fin_t    fin_reg;

    logic        fin_free;
    logic        adv;
    logic        take_in;

    mode_t       cur_mode;
    logic        hex;
    logic        sgn;
    logic        bad;
    logic        wide;
    aip_digit_t  dig;
    logic [63:0] acc_base;
    logic [63:0] acc_next;
    logic        neg_next;
    logic        ill_next;
    logic        neg_base;
    logic        ill_base;

    assign fin_free     = !fin_v_reg || fin_ready;
    assign adv          = in_v_reg && (!last_reg || fin_free);
    assign char_in.ready = !in_v_reg || adv;
    assign take_in      = char_in.valid && char_in.ready;

    assign fin_valid = fin_v_reg;
    assign fin       = fin_reg;

    always_comb
    begin
        cur_mode = first_reg ? in_mode_reg : mode_reg;
        acc_base = first_reg ? '0 : acc_reg;
        neg_base = first_reg ? 1'b0 : neg_reg;
        ill_base = first_reg ? 1'b0 : ill_reg;
        hex  = (cur_mode == MODE_H32) || (cur_mode == MODE_H64);
        sgn  = (cur_mode == MODE_S32) || (cur_mode == MODE_S64);
        wide = (cur_mode == MODE_S64) || (cur_mode == MODE_U64) || (cur_mode == MODE_H64);
        bad  = cur_mode > MODE_H64;
        dig  = aip_digit(ch_reg, hex);
        acc_next = acc_base;
        neg_next = neg_base;
        ill_next = ill_base;
        if (!ill_base)
        begin
            priority if (bad)
                ill_next = 1'b1;
            else if (dig.ok)
            begin
                if (hex)
                    acc_next = {acc_base[59:0], 4'b0000} | {60'd0, dig.val};
                else
                    acc_next = {acc_base[60:0], 3'b000} + {acc_base[62:0], 1'b0}
                             + {60'd0, dig.val};
            end
            else if (sgn && first_reg && ch_reg == CH_MINUS)
                neg_next = 1'b1;
            else if (sgn && first_reg && ch_reg == CH_PLUS)
                neg_next = neg_base;
            else
                ill_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            fin_v_reg <= 1'b0;
            first_reg <= 1'b1;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            ill_reg   <= 1'b0;
            mode_reg  <= MODE_S32;
        end
        else
        begin
            if (take_in)
                in_v_reg <= 1'b1;
            else if (adv)
                in_v_reg <= 1'b0;

            if (adv && last_reg)
                fin_v_reg <= 1'b1;
            else if (fin_ready)
                fin_v_reg <= 1'b0;

            if (adv)
            begin
                mode_reg <= cur_mode;
                if (last_reg)
                begin
                    // rearm for the next string
                    first_reg <= 1'b1;
                    acc_reg   <= '0;
                    neg_reg   <= 1'b0;
                    ill_reg   <= 1'b0;
                end
                else
                begin
                    first_reg <= 1'b0;
                    acc_reg   <= acc_next;
                    neg_reg   <= neg_next;
                    ill_reg   <= ill_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            ch_reg      <= char_in.char_code;
            last_reg    <= char_in.last_char;
            in_mode_reg <= char_in.mode;
        end
        if (adv && last_reg)
        begin
            fin_reg.acc      <= acc_next;
            fin_reg.negative <= neg_next;
            fin_reg.illegal  <= ill_next;
            fin_reg.wide     <= wide;
        end
    end

endmodule

### hw/rtl/aip_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_finish
// Apply sign, width mask and reject, and hold the result for the sink.
// ----------------------------------------------------------------------------
module aip_finish
    import aip_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fin_valid,
    output logic              fin_ready,
    input  aip_fin_t          fin,
    aip_result_if.source      result
);

    logic        out_v_reg;
    logic [63:0] value_reg;
    logic        rej_reg;
    logic [63:0] value_next;
    logic        load;

    assign fin_ready = !out_v_reg || result.ready;
    assign load      = fin_valid && fin_ready;

    always_comb
    begin
        value_next = fin.negative ? (64'd0 - fin.acc) : fin.acc;
        if (!fin.wide)
            value_next = {32'd0, value_next[31:0]};
        if (fin.illegal)
            value_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (load)
            out_v_reg <= 1'b1;
        else if (result.ready)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
            rej_reg   <= fin.illegal;
        end
    end

    assign result.valid    = out_v_reg;
    assign result.value    = value_reg;
    assign result.rejected = rej_reg;

endmodule

### hw/rtl/ascii_integer_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_integer_parse
// Converts an ASCII numeric string, one character per transaction, to an
// integer bit pattern in signed/unsigned decimal or hex at 32 or 64 bits.
// ----------------------------------------------------------------------------
// Usage:
//   char_in carries one character per transaction, first to last, with
//   last_char marking the final one. mode is sampled on the first character
//   of each string and held until the string ends.
//   result carries one transaction per string: value (sign applied, 32-bit
//   modes zero-extended) and rejected; a rejected string reports value 0.
//   Throughput: one character per cycle, sustained across string borders,
//   while result.ready stays high. Pipeline: three register stages (input
//   register, accumulator/finish register, output register); the last
//   character passes from the input register to the finish register and
//   then to the output register, which drives result.valid.
//   The per-character path is one shift-add (decimal) or shift-or (hex) of the 64-bit accumulator.
//   Reset clears all valids and rearms for a new string; no clearing pass.
//   Stall: when result.ready is low a full output register holds; a finished
//   string can wait in the finish register and the character in the input
//   register keeps accumulating unless it is a last character, so
//   backpressure reaches char_in.ready only when the output and finish
//   registers both hold a result and a last character waits in the input.
// ----------------------------------------------------------------------------
module ascii_integer_parse
    import aip_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    aip_char_if.sink      char_in,
    aip_result_if.source  result
);

    // Handoff of a finished string between accumulator and output stage
    logic     fin_valid;
    logic     fin_ready;
    aip_fin_t fin;

    // Register each character and advance the running value
    aip_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_in),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin)
    );

    // Negate, mask to width, drop to zero on reject, and hold for the sink
    aip_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin),
        .result    (result)
    );

endmodule
